// ----- rtl/core/yuvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types and constants of the 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

	// byte order codes; only bit 1 is looked at for the planar case
	localparam logic [1:0] ORDER_UYVY   = 2'd0;
	localparam logic [1:0] ORDER_YUYV   = 2'd1;
	localparam logic [1:0] ORDER_PLANAR = 2'd2;

	// width of one registered chroma product term
	localparam int unsigned TERM_W = 18;
	// width of one channel accumulator before the shift
	localparam int unsigned SUM_W  = 20;

	// chroma contributions shared by both lanes
	typedef struct packed {
		logic signed [TERM_W-1:0] red;
		logic signed [TERM_W-1:0] green;
		logic signed [TERM_W-1:0] blue;
	} chroma_t;

	// stage enables of the pipeline
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

	// one output pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

endpackage

// ----- rtl/core/yuvrgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_chroma
// Chroma product terms for red, green and blue, registered once per request.
// ----------------------------------------------------------------------------
module yuvrgb_chroma (
	input  logic                  clk,
	input  yuvrgb_pkg::pipe_ctl_t ctl,
	input  logic [7:0]            u_s1,
	input  logic [7:0]            v_s1,
	output yuvrgb_pkg::chroma_t   chroma_s2
);
	import yuvrgb_pkg::*;

	logic signed [7:0]        d;
	logic signed [7:0]        e;
	logic signed [TERM_W-1:0] d_ext;
	logic signed [TERM_W-1:0] e_ext;
	logic signed [TERM_W-1:0] e409;
	logic signed [TERM_W-1:0] d100;
	logic signed [TERM_W-1:0] e208;
	logic signed [TERM_W-1:0] d516;

	// offset binary to two's complement: x - 128 is x with the top bit flipped
	assign d = $signed({~u_s1[7], u_s1[6:0]});
	assign e = $signed({~v_s1[7], v_s1[6:0]});
	assign d_ext = $signed({{(TERM_W-8){d[7]}}, d});
	assign e_ext = $signed({{(TERM_W-8){e[7]}}, e});

	// constant products, all fit in the term width
	assign e409 = e_ext * 18'sd409;
	assign d100 = d_ext * 18'sd100;
	assign e208 = e_ext * 18'sd208;
	assign d516 = d_ext * 18'sd516;

	// product register
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			chroma_s2.red   <= e409;
			chroma_s2.green <= 18'sd0 - d100 - e208;
			chroma_s2.blue  <= d516;
		end
	end

endmodule

// ----- rtl/core/yuvrgb_lane.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_lane
// One pixel lane: scales luma, adds the shared chroma terms, rounds and clamps.
// ----------------------------------------------------------------------------
module yuvrgb_lane (
	input  logic                  clk,
	input  yuvrgb_pkg::pipe_ctl_t ctl,
	input  logic [7:0]            y_s1,
	input  yuvrgb_pkg::chroma_t   chroma_s2,
	output yuvrgb_pkg::rgb_t      pixel_s3
);
	import yuvrgb_pkg::*;

	logic [7:0]  c;
	logic [16:0] cy_s2;

	// luma below 16 counts as 16
	assign c = (y_s1 < 8'd16) ? 8'd0 : (y_s1 - 8'd16);

	// luma product register
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			cy_s2 <= 17'(c) * 17'd298;
		end
	end

	// round, floor shift by 8 and clamp to 0..255
	function automatic logic [7:0] sat8(input logic [16:0] cy, input logic signed [TERM_W-1:0] t);
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-9:0] q;
		sum = $signed({{(SUM_W-17){1'b0}}, cy}) + $signed({{(SUM_W-TERM_W){t[TERM_W-1]}}, t})
			+ 20'sd128;
		q = sum[SUM_W-1:8];
		if (q[SUM_W-9]) begin
			sat8 = 8'd0;
		end else if (q[SUM_W-10:8] != '0) begin
			sat8 = 8'd255;
		end else begin
			sat8 = q[7:0];
		end
	endfunction

	// output register of the lane
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			pixel_s3.red   <= sat8(cy_s2, chroma_s2.red);
			pixel_s3.green <= sat8(cy_s2, chroma_s2.green);
			pixel_s3.blue  <= sat8(cy_s2, chroma_s2.blue);
		end
	end

endmodule

// ----- rtl/core/yuv422_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter
// 4:2:2 macropixel to two RGB888 pixels, BT.601 integer conversion.
// ----------------------------------------------------------------------------
// Usage
//   s_tdata carries one macropixel of four bytes in memory order; m_tdata
//   returns the two pixels that share its chroma. Both sides are streams
//   with tvalid/tready; a request moves when both are high on a clock edge.
//   cfg_valid/cfg_data write the byte order (0 UYVY, 1 YUYV, 2 or 3 planar
//   Y0 Y1 U V); cfg_ready is always high. Write it only while idle.
// Pipeline and throughput
//   m_tvalid rises once a pixel pair has passed an unpack register and a
//   product register into the clamp register that is the output. One
//   macropixel is taken every clock while the output is not stalled; two
//   lanes convert the two luma samples side by side using one shared set
//   of chroma products.
// Reset
//   arst_n clears the pipeline valid flags and sets the byte order to UYVY.
// Stall
//   A full stage holds while the next one holds, the last one while m_tready
//   is low, so s_tready stays high while any stage has a bubble or m_tready is high.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,   // byte_order
	// macropixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // byte_first, byte_second, byte_third, byte_fourth
	// pixel pair output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata     // left_red, left_green, left_blue,
	                                // right_red, right_green, right_blue
);
	import yuvrgb_pkg::*;

	logic [1:0] byte_order_q;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       en_s1;
	pipe_ctl_t  ctl;
	logic [7:0] y0_nxt, y1_nxt, u_nxt, v_nxt;
	logic [7:0] y0_s1, y1_s1, u_s1, v_s1;
	chroma_t    chroma_s2;
	rgb_t       left_s3;
	rgb_t       right_s3;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= ORDER_UYVY;
		end else if (cfg_valid) begin
			byte_order_q <= cfg_data;
		end
	end

	// stage enables, a stage loads when it is empty or its successor moves
	assign ctl.en_s3 = !valid_s3 || m_tready;
	assign ctl.en_s2 = !valid_s2 || ctl.en_s3;
	assign en_s1     = !valid_s1 || ctl.en_s2;
	assign s_tready  = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// byte order unpacking
	always_comb begin
		if (byte_order_q[1]) begin
			y0_nxt = s_tdata[7:0];
			y1_nxt = s_tdata[15:8];
			u_nxt  = s_tdata[23:16];
			v_nxt  = s_tdata[31:24];
		end else if (byte_order_q == ORDER_YUYV) begin
			y0_nxt = s_tdata[7:0];
			u_nxt  = s_tdata[15:8];
			y1_nxt = s_tdata[23:16];
			v_nxt  = s_tdata[31:24];
		end else begin
			u_nxt  = s_tdata[7:0];
			y0_nxt = s_tdata[15:8];
			v_nxt  = s_tdata[23:16];
			y1_nxt = s_tdata[31:24];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y0_s1 <= y0_nxt;
			y1_s1 <= y1_nxt;
			u_s1  <= u_nxt;
			v_s1  <= v_nxt;
		end
	end

	// shared chroma products
	yuvrgb_chroma u_chroma (
		.clk       (clk),
		.ctl       (ctl),
		.u_s1      (u_s1),
		.v_s1      (v_s1),
		.chroma_s2 (chroma_s2)
	);

	// two pixel lanes
	yuvrgb_lane u_lane_left (
		.clk       (clk),
		.ctl       (ctl),
		.y_s1      (y0_s1),
		.chroma_s2 (chroma_s2),
		.pixel_s3  (left_s3)
	);

	yuvrgb_lane u_lane_right (
		.clk       (clk),
		.ctl       (ctl),
		.y_s1      (y1_s1),
		.chroma_s2 (chroma_s2),
		.pixel_s3  (right_s3)
	);

	// merge the lanes onto the output bus
	assign m_tvalid = valid_s3;
	assign m_tdata  = {right_s3.blue, right_s3.green, right_s3.red,
	                   left_s3.blue, left_s3.green, left_s3.red};

endmodule

// ----- rtl/core/yuvrgb_checker.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module yuvrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output request dropped while stalled");

	// a stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// a free output side never blocks the input
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output is taken");

	// an empty output register means room upstream
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind yuv422_to_rgb_converter yuvrgb_checker u_yuvrgb_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the 4:2:2 macropixel to RGB888 converter.
// A short table of macropixels walks every byte order, the black and white
// levels, luma below the black level and clamping at both ends. Random
// macropixels follow under changing byte orders and changing back-pressure
// on both streams. Every pixel pair is compared channel by channel with a
// typed-in result or an integer BT.601 prediction kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
	import yuvrgb_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int CHUNK_ITEMS  = 57;
	localparam int CHUNKS       = 4;

	// BT.601 integer coefficients
	localparam int LUMA_GAIN = 298;
	localparam int RED_CR    = 409;
	localparam int GREEN_CB  = 100;
	localparam int GREEN_CR  = 208;
	localparam int BLUE_CB   = 516;

	// spare byte order code, decoded as planar
	localparam logic [1:0] ORDER_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  order;
		logic [31:0] word;     // byte_first in the low byte
		logic        typed;    // result typed in below, else predicted
		logic [47:0] pair;
	} stim_row_t;

	localparam int DIR_ROWS = 19;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data  = ORDER_UYVY;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;    // byte_first, byte_second, byte_third, byte_fourth
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;           // left_red, left_green, left_blue,
	                                // right_red, right_green, right_blue

	logic [47:0] pairs_due [$];
	logic [47:0] oldest_pair;
	logic [1:0]  order_now = ORDER_UYVY;
	int          s_idle_pct  = 0;
	int          m_stall_pct = 0;
	int          error_count = 0;
	int          pairs_seen  = 0;
	int          items_sent  = 0;
	int          order_writes = 0;
	int          quiet_cycles = 0;
	string       channel_names [6] = '{"left_red", "left_green", "left_blue",
	                                   "right_red", "right_green", "right_blue"};

	// directed macropixels, grouped by byte order
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ORDER_UYVY,   32'h00000000, 1'b1, 48'h009A00009A00},
		'{ORDER_UYVY,   32'hFFFFFFFF, 1'b1, 48'hFF7DFFFF7DFF},
		'{ORDER_UYVY,   32'hEB801080, 1'b1, 48'hFFFFFF000000},
		'{ORDER_UYVY,   32'h0F800080, 1'b1, 48'h000000000000},
		'{ORDER_UYVY,   32'h80FF8000, 1'b0, 48'h0},
		'{ORDER_UYVY,   32'h10F0EB0F, 1'b0, 48'h0},
		'{ORDER_YUYV,   32'h801080EB, 1'b1, 48'h000000FFFFFF},
		'{ORDER_YUYV,   32'h00000000, 1'b1, 48'h009A00009A00},
		'{ORDER_YUYV,   32'hFFFFFFFF, 1'b1, 48'hFF7DFFFF7DFF},
		'{ORDER_YUYV,   32'h4000C020, 1'b0, 48'h0},
		'{ORDER_YUYV,   32'hA55AC33C, 1'b0, 48'h0},
		'{ORDER_PLANAR, 32'h8080EB10, 1'b1, 48'hFFFFFF000000},
		'{ORDER_PLANAR, 32'h00FF0FFF, 1'b0, 48'h0},
		'{ORDER_PLANAR, 32'hFF000110, 1'b0, 48'h0},
		'{ORDER_PLANAR, 32'h00000000, 1'b1, 48'h009A00009A00},
		'{ORDER_SPARE,  32'h808000EB, 1'b1, 48'h000000FFFFFF},
		'{ORDER_SPARE,  32'hFFFFFFFF, 1'b1, 48'hFF7DFFFF7DFF},
		'{ORDER_SPARE,  32'h12345678, 1'b0, 48'h0},
		'{ORDER_SPARE,  32'h0180EF11, 1'b0, 48'h0}
	};

	yuv422_to_rgb_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor shift by 8, then limit to one byte
	function automatic logic [7:0] clamp_channel(input int sum);
		int q;
		q = sum >>> 8;
		if (q < 0)
			return 8'd0;
		if (q > 255)
			return 8'd255;
		return q[7:0];
	endfunction

	function automatic rgb_t convert_pixel(input logic [7:0] luma, input logic [7:0] cb,
		input logic [7:0] cr);
		int   c;
		int   d;
		int   e;
		rgb_t px;
		// luma under the black level counts as black
		c = (luma < 8'd16) ? 0 : int'(luma) - 16;
		d = int'(cb) - 128;
		e = int'(cr) - 128;
		px.red   = clamp_channel(LUMA_GAIN * c + RED_CR * e + 128);
		px.green = clamp_channel(LUMA_GAIN * c - GREEN_CB * d - GREEN_CR * e + 128);
		px.blue  = clamp_channel(LUMA_GAIN * c + BLUE_CB * d + 128);
		return px;
	endfunction

	function automatic logic [47:0] predict_pixel_pair(input logic [1:0] order,
		input logic [31:0] word);
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] cb;
		logic [7:0] cr;
		case (order)
			ORDER_UYVY: begin
				cb = word[7:0];   y0 = word[15:8];  cr = word[23:16]; y1 = word[31:24];
			end
			ORDER_YUYV: begin
				y0 = word[7:0];   cb = word[15:8];  y1 = word[23:16]; cr = word[31:24];
			end
			// the spare code decodes as planar
			default: begin
				y0 = word[7:0];   y1 = word[15:8];  cb = word[23:16]; cr = word[31:24];
			end
		endcase
		return {convert_pixel(y1, cb, cr), convert_pixel(y0, cb, cr)};
	endfunction

	// random sample, weighted towards the black level, the top and mid chroma
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(9))
			0: return 8'($urandom_range(20));
			1: return 8'($urandom_range(255, 228));
			2: return 8'($urandom_range(136, 120));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// offer one macropixel and record its pair once the request is taken
	task automatic send_macropixel(input logic [31:0] word, input logic [47:0] pair);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		pairs_due.insert(pairs_due.size(), pair);
		items_sent++;
	endtask

	// hold the input until the pipeline is empty, then change the byte order
	task automatic write_byte_order(input logic [1:0] order);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pairs_due.size() != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= order;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		order_now = order;
		order_writes++;
	endtask

	// output side: compare each pair and drive back-pressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			pairs_seen++;
			if (pairs_due.size() == 0) begin
				error_count++;
				$display("%0t: unexpected pixel pair, actual %h", $time, m_tdata);
			end else begin
				oldest_pair = pairs_due.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (m_tdata[8*k +: 8] !== oldest_pair[8*k +: 8]) begin
						error_count++;
						$display("%0t: %s expected %0d, actual %0d", $time,
							channel_names[k], oldest_pair[8*k +: 8], m_tdata[8*k +: 8]);
					end
				end
			end
		end
		m_tready <= ($urandom_range(99) >= m_stall_pct);
	end

	// watchdog on cycles with no request moving on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [31:0] word;
		logic [1:0]  order;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, first rows run on the reset byte order
		s_idle_pct  = 24;
		m_stall_pct = 62;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].order != order_now)
				write_byte_order(dir_rows[i].order);
			send_macropixel(dir_rows[i].word, dir_rows[i].typed ? dir_rows[i].pair :
				predict_pixel_pair(order_now, dir_rows[i].word));
		end

		// random macropixels in three pressure phases
		for (int phase = 0; phase < 3; phase++) begin
			s_idle_pct  = (phase == 0) ? 24 : (phase == 1) ? 62 : 0;
			m_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 24 : 0;
			for (int chunk = 0; chunk < CHUNKS; chunk++) begin
				order = (phase == 0 && chunk == 0) ? ORDER_UYVY : 2'($urandom_range(3));
				write_byte_order(order);
				for (int n = 0; n < CHUNK_ITEMS; n++) begin
					word = ($urandom_range(3) == 0) ? 32'($urandom()) :
						{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
					send_macropixel(word, predict_pixel_pair(order_now, word));
				end
			end
		end

		// drain and let the pipeline settle
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pairs_due.size() != 0);
		repeat (8) @(posedge clk);

		$display("covered %0d macropixels (%0d from the directed table), %0d pixel pairs",
			items_sent, DIR_ROWS, pairs_seen);
		$display("byte order written %0d times across UYVY, YUYV, planar and the spare code",
			order_writes);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/yuvrgb_pkg.sv
rtl/core/yuvrgb_chroma.sv
rtl/core/yuvrgb_lane.sv
rtl/core/yuv422_to_rgb_converter.sv
rtl/core/yuvrgb_checker.sv
tb/sv/testbench.sv
